// File: rtl/blfu_pkg.sv
// ----------------------------------------------------------------------------
// blfu_pkg
// Shared constants and types of the block cache LFU replacement core.
// ----------------------------------------------------------------------------
package blfu_pkg;

  localparam int CACHED_SLOTS_DEF  = 3;
  localparam int BLOCK_ID_BITS_DEF = 24;
  localparam int STREAM_BITS_DEF   = 4;
  localparam int SCORE_BITS_DEF    = 16;

  // threshold width and result slot width are fixed by the request format
  localparam int BEGIN_BITS    = 25;
  localparam int SLOT_OUT_BITS = 2;

  // controller -> datapath commands
  typedef struct packed {
    logic load;   // capture the accepted request
    logic exec;   // look up, update tags/scores, load result register
  } cmd_t;

endpackage

// File: rtl/blfu_if.sv
// ----------------------------------------------------------------------------
// blfu_req_if / blfu_rsp_if
// Valid/ready channels for lookup requests and their results.
// ----------------------------------------------------------------------------
interface blfu_req_if #(
  parameter int BLOCK_ID_BITS = blfu_pkg::BLOCK_ID_BITS_DEF,
  parameter int STREAM_BITS   = blfu_pkg::STREAM_BITS_DEF
);
  import blfu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [BLOCK_ID_BITS-1:0] block_id;
  logic [STREAM_BITS-1:0]   stream_index;
  logic [BEGIN_BITS-1:0]    uncached_begin;

  modport source (output valid, block_id, stream_index, uncached_begin, input ready);
  modport sink   (input valid, block_id, stream_index, uncached_begin, output ready);
endinterface

interface blfu_rsp_if;
  import blfu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic [SLOT_OUT_BITS-1:0] slot;
  logic                     bypass;

  modport source (output valid, hit, slot, bypass, input ready);
  modport sink   (input valid, hit, slot, bypass, output ready);
endinterface

// File: rtl/block_cache_lfu_replacement_core.sv
// ----------------------------------------------------------------------------
// block_cache_lfu_replacement_core
// Slot selection for a small block cache with LFU replacement and a bypass slot.
// ----------------------------------------------------------------------------
// Each request (block id, stream, stream's uncached threshold) yields one result:
// hit flag, slot and bypass flag. Ids at or above the threshold use the single
// bypass slot (slot CACHED_SLOTS); others are matched against the cached slots,
// where a hit bumps a saturating use score and a miss takes the first slot with
// the lowest score. A request is captured first; its execute step then does the
// parallel tag compare, the linear minimum search over the scores and the update,
// and no new request is accepted before it has executed. The result sits in
// an output register; the next request is accepted while it waits, but its
// execute cycle holds until that result is taken. No clearing pass after reset.
module block_cache_lfu_replacement_core #(
  parameter int CACHED_SLOTS  = blfu_pkg::CACHED_SLOTS_DEF,
  parameter int BLOCK_ID_BITS = blfu_pkg::BLOCK_ID_BITS_DEF,
  parameter int STREAM_BITS   = blfu_pkg::STREAM_BITS_DEF,
  parameter int SCORE_BITS    = blfu_pkg::SCORE_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  blfu_req_if.sink  req,
  blfu_rsp_if.source rsp
);
  import blfu_pkg::*;

  cmd_t cmd;

  blfu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  blfu_dp #(
    .CACHED_SLOTS  (CACHED_SLOTS),
    .BLOCK_ID_BITS (BLOCK_ID_BITS),
    .STREAM_BITS   (STREAM_BITS),
    .SCORE_BITS    (SCORE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .block_id       (req.block_id),
    .stream_index   (req.stream_index),
    .uncached_begin (req.uncached_begin),
    .hit            (rsp.hit),
    .slot           (rsp.slot),
    .bypass         (rsp.bypass)
  );

endmodule

// File: rtl/blfu_ctrl.sv
// ----------------------------------------------------------------------------
// blfu_ctrl
// Request sequencer: capture, execute, and result register handshake.
// ----------------------------------------------------------------------------
module blfu_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output blfu_pkg::cmd_t cmd
);
  import blfu_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;

  always_comb begin
    cmd.load = (state == ST_IDLE) && in_valid && in_ready;
    // execute only when the result register is free or being emptied
    cmd.exec = (state == ST_EXEC) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_ready  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd.load) begin
            in_ready <= 1'b0;
            state    <= ST_EXEC;
          end else begin
            in_ready <= 1'b1;
          end
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
        end
        ST_EXEC: begin
          // no exec here means the old result is still waiting
          if (cmd.exec) begin
            out_valid <= 1'b1;
            in_ready  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_no_ready_in_exec: assert property (@(posedge clk) disable iff (rst)
    state == ST_EXEC |-> !in_ready)
    else $error("ready high while a request is in flight");

  a_load_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_EXEC)
    else $error("captured request did not move to execute");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> out_valid)
    else $error("executed request produced no result");

endmodule

// File: rtl/blfu_dp.sv
// ----------------------------------------------------------------------------
// blfu_dp
// Tag store, use scores, victim search and result register.
// ----------------------------------------------------------------------------
module blfu_dp #(
  parameter int CACHED_SLOTS  = blfu_pkg::CACHED_SLOTS_DEF,
  parameter int BLOCK_ID_BITS = blfu_pkg::BLOCK_ID_BITS_DEF,
  parameter int STREAM_BITS   = blfu_pkg::STREAM_BITS_DEF,
  parameter int SCORE_BITS    = blfu_pkg::SCORE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  blfu_pkg::cmd_t                       cmd,
  input  logic [BLOCK_ID_BITS-1:0]             block_id,
  input  logic [STREAM_BITS-1:0]               stream_index,
  input  logic [blfu_pkg::BEGIN_BITS-1:0]      uncached_begin,
  output logic                                 hit,
  output logic [blfu_pkg::SLOT_OUT_BITS-1:0]   slot,
  output logic                                 bypass
);
  import blfu_pkg::*;

  localparam int IDX_W  = (CACHED_SLOTS > 1) ? $clog2(CACHED_SLOTS) : 1;
  localparam int SLOT_W = $clog2(CACHED_SLOTS + 1);
  localparam int CMP_W  = (BLOCK_ID_BITS > BEGIN_BITS) ? BLOCK_ID_BITS : BEGIN_BITS;

  // captured request
  logic [BLOCK_ID_BITS-1:0] req_id;
  logic [STREAM_BITS-1:0]   req_stream;
  logic [BEGIN_BITS-1:0]    req_begin;

  // cached slots
  logic [BLOCK_ID_BITS-1:0] slot_block  [CACHED_SLOTS];
  logic [STREAM_BITS-1:0]   slot_stream [CACHED_SLOTS];
  logic [CACHED_SLOTS-1:0]  slot_valid;
  logic [SCORE_BITS-1:0]    use_score   [CACHED_SLOTS];

  // bypass slot
  logic [BLOCK_ID_BITS-1:0] byp_block;
  logic [STREAM_BITS-1:0]   byp_stream;
  logic                     byp_valid;

  logic                    to_bypass;
  logic                    byp_match;
  logic [CACHED_SLOTS-1:0] match;
  logic                    hit_any;
  logic [IDX_W-1:0]        hit_idx;
  logic [IDX_W-1:0]        victim;
  logic [SCORE_BITS-1:0]   low;

  assign to_bypass = CMP_W'(req_id) >= CMP_W'(req_begin);
  assign byp_match = byp_valid && (byp_block == req_id) && (byp_stream == req_stream);

  always_comb begin
    for (int i = 0; i < CACHED_SLOTS; i++) begin
      match[i] = slot_valid[i] && (slot_block[i] == req_id) &&
                 (slot_stream[i] == req_stream);
    end
  end

  // lowest matching slot wins
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = CACHED_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  // first slot with the lowest score
  always_comb begin
    low    = use_score[0];
    victim = '0;
    for (int i = 1; i < CACHED_SLOTS; i++) begin
      if (use_score[i] < low) begin
        low    = use_score[i];
        victim = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_id     <= block_id;
      req_stream <= stream_index;
      req_begin  <= uncached_begin;
    end
    if (cmd.exec) begin
      bypass <= to_bypass;
      if (to_bypass) begin
        hit  <= byp_match;
        slot <= SLOT_OUT_BITS'(SLOT_W'(CACHED_SLOTS));
        if (!byp_match) begin
          byp_block  <= req_id;
          byp_stream <= req_stream;
        end
      end else if (hit_any) begin
        hit  <= 1'b1;
        slot <= SLOT_OUT_BITS'(hit_idx);
      end else begin
        hit                 <= 1'b0;
        slot                <= SLOT_OUT_BITS'(victim);
        slot_block[victim]  <= req_id;
        slot_stream[victim] <= req_stream;
      end
    end
  end

  // control-side state: valid bits and scores
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      byp_valid  <= 1'b0;
      for (int i = 0; i < CACHED_SLOTS; i++) begin
        use_score[i] <= '0;
      end
    end else if (cmd.exec) begin
      if (to_bypass) begin
        byp_valid <= 1'b1;
      end else if (hit_any) begin
        if (use_score[hit_idx] != '1) begin
          use_score[hit_idx] <= use_score[hit_idx] + 1'b1;
        end
      end else begin
        slot_valid[victim] <= 1'b1;
        use_score[victim]  <= '0;
      end
    end
  end

  // a tag is only ever filled on a miss, so no two cached slots hold it
  a_unique_tags: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> $onehot0(match))
    else $error("same tag resident in two cached slots");

  a_miss_fills_victim: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && !to_bypass && !hit_any |=>
      slot_valid[$past(victim)] && use_score[$past(victim)] == '0)
    else $error("miss did not claim the victim slot");

  a_bypass_keeps_scores: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && to_bypass |=> use_score[0] == $past(use_score[0]))
    else $error("bypass request changed a use score");

endmodule
